/* design/oofm_pkg.sv */
// ----------------------------------------------------------------------------
// oofm_pkg
// Shared constants and controller/datapath interface types for the offset
// outlier filter.
// ----------------------------------------------------------------------------
package oofm_pkg;

   localparam int DEF_MAX_ITEMS   = 64;
   localparam int DEF_OFFSET_BITS = 24;

   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 16;
   localparam int REG_SLOPE  = 0;
   localparam int REG_BIAS   = 1;

   localparam logic [15:0] SLOPE_RESET = 16'd1311;
   localparam logic [15:0] BIAS_RESET  = 16'd100;

   localparam int IDX_W       = 6;
   localparam int COUNT_W     = 7;
   localparam int EST_W       = 24;
   localparam int RSP_TDATA_W = 40;

   typedef struct packed {
      logic idle;
      logic load;
      logic rank;
      logic scan;
      logic sum;
      logic div;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic rank_done;
      logic scan_done;
      logic sum_done;
      logic div_done;
      logic emit_done;
   } sts_type;

endpackage

/* design/oofm_ctrl.sv */
// ----------------------------------------------------------------------------
// oofm_ctrl
// Phase sequencer: load, rank, run scan, kept sum, divide, emit.
// ----------------------------------------------------------------------------
module oofm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tlast,
   output logic             req_tready,
   input  oofm_pkg::sts_type sts,
   output oofm_pkg::cmd_type cmd
);
   import oofm_pkg::*;

   localparam logic [2:0] S_LOAD = 3'd0;
   localparam logic [2:0] S_RANK = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_SUM  = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_EMIT = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_LOAD: if (req_tvalid && req_tlast) state_in = S_RANK;
         S_RANK: if (sts.rank_done) state_in = S_SCAN;
         S_SCAN: if (sts.scan_done) state_in = S_SUM;
         S_SUM:  if (sts.sum_done) state_in = S_DIV;
         S_DIV:  if (sts.div_done) state_in = S_EMIT;
         S_EMIT: if (sts.emit_done) state_in = S_LOAD;
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_LOAD);
   assign cmd.idle   = (state_ff == S_LOAD);
   assign cmd.load   = (state_ff == S_LOAD) && req_tvalid;
   assign cmd.rank   = (state_ff == S_RANK);
   assign cmd.scan   = (state_ff == S_SCAN);
   assign cmd.sum    = (state_ff == S_SUM);
   assign cmd.div    = (state_ff == S_DIV);
   assign cmd.emit   = (state_ff == S_EMIT);

endmodule

/* design/oofm_dp.sv */
// ----------------------------------------------------------------------------
// oofm_dp
// Offset store, pairwise ranking, run scan, kept sum, serial divider and
// result register.
// ----------------------------------------------------------------------------
module oofm_dp #(
   parameter int MAX_ITEMS   = oofm_pkg::DEF_MAX_ITEMS,
   parameter int OFFSET_BITS = oofm_pkg::DEF_OFFSET_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wen,
   input  logic [oofm_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [oofm_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic [OFFSET_BITS-1:0]          req_offset,
   input  oofm_pkg::cmd_type               cmd,
   output oofm_pkg::sts_type               sts,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [oofm_pkg::IDX_W-1:0]      rsp_index,
   output logic                            rsp_keep,
   output logic [oofm_pkg::COUNT_W-1:0]    rsp_count,
   output logic [oofm_pkg::EST_W-1:0]      rsp_estimate,
   output logic                            rsp_overflow,
   output logic                            rsp_last
);
   import oofm_pkg::*;

   localparam int IW  = $clog2(MAX_ITEMS);
   localparam int CW  = $clog2(MAX_ITEMS + 1);
   localparam int SW  = OFFSET_BITS + CW;
   localparam int NW  = SW + 1;
   localparam int PW  = 16 + OFFSET_BITS + 1;
   localparam int DCW = $clog2(NW + 1);

   // memories
   logic [OFFSET_BITS-1:0] store_mem [MAX_ITEMS];
   logic [OFFSET_BITS-1:0] sv_mem    [MAX_ITEMS];
   logic [IW-1:0]          rank_mem  [MAX_ITEMS];
   logic [OFFSET_BITS-1:0] a_ff, b_ff, sv_rd_ff;
   logic [IW-1:0]          rank_rd_ff;

   logic [15:0] slope_ff, slope_in, bias_ff, bias_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          ovf_ff, ovf_in;
   logic [IW-1:0] ri_ff, ri_in, rj_ff, rj_in, pi_ff, pi_in, pj_ff, pj_in, acc_ff, acc_in;
   logic          iss_end_ff, iss_end_in, pv_ff, pv_in, plast_ff, plast_in;
   logic [CW-1:0] k_ff, k_in, start_ff, start_in, bbeg_ff, bbeg_in, bend_ff, bend_in;
   logic [1:0]    ph_ff, ph_in;
   logic [OFFSET_BITS-1:0] prev_ff, prev_in, cur_ff, cur_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic [CW-1:0] s_ff, s_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [DCW-1:0] dcnt_ff, dcnt_in;
   logic          dstart_ff, dstart_in;
   logic [IW-1:0] e_ff, e_in;
   logic          rv_ff, rv_in;
   logic [IDX_W-1:0]   ridx_ff, ridx_in;
   logic               rkeep_ff, rkeep_in, rovf_ff, rovf_in, rlast_ff, rlast_in;
   logic [COUNT_W-1:0] rcnt_ff, rcnt_in;
   logic [EST_W-1:0]   rest_ff, rest_in;

   logic [CW-1:0]  cnt_m1, count_w, run_w, best_w, s_addr;
   logic [IW-1:0]  last_idx, acc_next, sv_raddr;
   logic           full, less, rank_wr;
   logic [OFFSET_BITS:0] ab_sum;
   logic [PW:0]    tol_w;
   logic [OFFSET_BITS-1:0] diff_w;
   logic           brk;
   logic [NW-1:0]  num_w;
   logic [CW:0]    trial_w, trial_sub;
   logic [31:0]    idx32, cnt32;
   logic [63:0]    est64;

   assign cnt_m1   = cnt_ff - CW'(1);
   assign last_idx = cnt_m1[IW-1:0];
   assign full     = (cnt_ff == CW'(MAX_ITEMS));
   assign count_w  = bend_ff - bbeg_ff;
   assign run_w    = k_ff - start_ff;
   assign best_w   = bend_ff - bbeg_ff;
   assign s_addr   = bbeg_ff + s_ff;
   assign sv_raddr = cmd.sum ? s_addr[IW-1:0] : k_ff[IW-1:0];

   assign less     = (b_ff < a_ff) || ((b_ff == a_ff) && (pj_ff < pi_ff));
   assign acc_next = ((pj_ff == '0) ? '0 : acc_ff) + IW'(less);
   assign rank_wr  = cmd.rank && pv_ff && plast_ff;

   assign ab_sum = {1'b0, prev_ff} + {1'b0, sv_rd_ff};
   assign tol_w  = (({1'b0, prod_ff} + (PW+1)'(65536)) >> 17) + (PW+1)'(bias_ff);
   assign diff_w = cur_ff - prev_ff;
   assign brk    = (cur_ff != prev_ff) && ((PW+1)'(diff_w) >= tol_w);

   assign num_w     = NW'(sum_ff) + NW'(count_w >> 1);
   assign trial_w   = {rem_ff, quo_ff[NW-1]};
   assign trial_sub = trial_w - {1'b0, count_w};

   assign idx32 = 32'(e_ff);
   assign cnt32 = 32'(count_w);
   assign est64 = 64'(quo_ff);

   always_ff @(posedge clock) begin
      if (cmd.load && !full) store_mem[cnt_ff[IW-1:0]] <= req_offset;
      a_ff <= store_mem[ri_ff];
      b_ff <= store_mem[rj_ff];
   end

   always_ff @(posedge clock) begin
      if (rank_wr) sv_mem[acc_next] <= a_ff;
      sv_rd_ff <= sv_mem[sv_raddr];
   end

   always_ff @(posedge clock) begin
      if (rank_wr) rank_mem[pi_ff] <= acc_next;
      rank_rd_ff <= rank_mem[e_ff];
   end

   always_comb begin
      sts = '0;
      slope_in = slope_ff;  bias_in = bias_ff;
      cnt_in = cnt_ff;  ovf_in = ovf_ff;
      ri_in = ri_ff;  rj_in = rj_ff;  pi_in = pi_ff;  pj_in = pj_ff;  acc_in = acc_ff;
      iss_end_in = iss_end_ff;  pv_in = 1'b0;  plast_in = plast_ff;
      k_in = k_ff;  start_in = start_ff;  bbeg_in = bbeg_ff;  bend_in = bend_ff;
      ph_in = ph_ff;  prev_in = prev_ff;  cur_in = cur_ff;  prod_in = prod_ff;
      s_in = s_ff;  sum_in = sum_ff;
      quo_in = quo_ff;  rem_in = rem_ff;  dcnt_in = dcnt_ff;  dstart_in = dstart_ff;
      e_in = e_ff;  rv_in = rv_ff;
      ridx_in = ridx_ff;  rkeep_in = rkeep_ff;  rovf_in = rovf_ff;  rlast_in = rlast_ff;
      rcnt_in = rcnt_ff;  rest_in = rest_ff;

      if (csr_wen) begin
         case (csr_addr)
            CSR_ADDR_W'(REG_SLOPE): slope_in = csr_wdata;
            CSR_ADDR_W'(REG_BIAS):  bias_in  = csr_wdata;
            default: ;
         endcase
      end

      if (cmd.idle) begin
         ri_in = '0;  rj_in = '0;  iss_end_in = 1'b0;
         k_in = '0;  start_in = '0;  bbeg_in = '0;  bend_in = '0;  ph_in = '0;
         s_in = '0;  sum_in = '0;  dstart_in = 1'b0;  e_in = '0;
      end

      if (cmd.load) begin
         if (full) ovf_in = 1'b1;
         else cnt_in = cnt_ff + CW'(1);
      end

      // rank: one compare per cycle, rank = count of smaller or earlier-equal
      if (cmd.rank) begin
         if (!iss_end_ff) begin
            pv_in = 1'b1;
            pi_in = ri_ff;
            pj_in = rj_ff;
            plast_in = (rj_ff == last_idx);
            if (rj_ff == last_idx) begin
               rj_in = '0;
               ri_in = ri_ff + IW'(1);
               if (ri_ff == last_idx) iss_end_in = 1'b1;
            end else begin
               rj_in = rj_ff + IW'(1);
            end
         end
         if (pv_ff) acc_in = acc_next;
         if (rank_wr && (pi_ff == last_idx)) sts.rank_done = 1'b1;
      end

      // scan sorted values for the longest run
      if (cmd.scan) begin
         case (ph_ff)
            2'd0: begin
               if (k_ff == cnt_ff) begin
                  sts.scan_done = 1'b1;
                  if (run_w > best_w) begin
                     bbeg_in = start_ff;
                     bend_in = k_ff;
                  end
               end else begin
                  ph_in = 2'd1;
               end
            end
            2'd1: begin
               if (k_ff == '0) begin
                  prev_in = sv_rd_ff;
                  k_in = CW'(1);
                  ph_in = 2'd0;
               end else begin
                  prod_in = PW'(slope_ff) * PW'(ab_sum);
                  cur_in = sv_rd_ff;
                  ph_in = 2'd2;
               end
            end
            default: begin
               if (brk) begin
                  if (run_w > best_w) begin
                     bbeg_in = start_ff;
                     bend_in = k_ff;
                  end
                  start_in = k_ff;
               end
               prev_in = cur_ff;
               k_in = k_ff + CW'(1);
               ph_in = 2'd0;
            end
         endcase
      end

      if (cmd.sum) begin
         if (ph_ff == 2'd0) begin
            if (s_ff == count_w) sts.sum_done = 1'b1;
            else ph_in = 2'd1;
         end else begin
            sum_in = sum_ff + SW'(sv_rd_ff);
            s_in = s_ff + CW'(1);
            ph_in = 2'd0;
         end
      end

      // restoring divide, one quotient bit per cycle
      if (cmd.div) begin
         if (!dstart_ff) begin
            quo_in = num_w;
            rem_in = '0;
            dcnt_in = DCW'(NW);
            dstart_in = 1'b1;
         end else if (dcnt_ff != '0) begin
            if (!trial_sub[CW]) begin
               rem_in = trial_sub[CW-1:0];
               quo_in = {quo_ff[NW-2:0], 1'b1};
            end else begin
               rem_in = trial_w[CW-1:0];
               quo_in = {quo_ff[NW-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff - DCW'(1);
         end else begin
            sts.div_done = 1'b1;
         end
      end

      if (cmd.emit) begin
         case (ph_ff)
            2'd0: ph_in = 2'd1;
            2'd1: begin
               rv_in = 1'b1;
               ridx_in = idx32[IDX_W-1:0];
               rkeep_in = (CW'(rank_rd_ff) >= bbeg_ff) && (CW'(rank_rd_ff) < bend_ff);
               rcnt_in = cnt32[COUNT_W-1:0];
               rest_in = est64[EST_W-1:0];
               rovf_in = ovf_ff;
               rlast_in = (e_ff == last_idx);
               ph_in = 2'd2;
            end
            default: begin
               if (rv_ff && rsp_ready) begin
                  rv_in = 1'b0;
                  ph_in = 2'd0;
                  if (e_ff == last_idx) begin
                     sts.emit_done = 1'b1;
                     cnt_in = '0;
                     ovf_in = 1'b0;
                  end else begin
                     e_in = e_ff + IW'(1);
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slope_ff <= SLOPE_RESET;  bias_ff <= BIAS_RESET;
         cnt_ff <= '0;  ovf_ff <= 1'b0;
         ri_ff <= '0;  rj_ff <= '0;  iss_end_ff <= 1'b0;  pv_ff <= 1'b0;
         k_ff <= '0;  start_ff <= '0;  bbeg_ff <= '0;  bend_ff <= '0;  ph_ff <= '0;
         s_ff <= '0;  sum_ff <= '0;  dcnt_ff <= '0;  dstart_ff <= 1'b0;
         e_ff <= '0;  rv_ff <= 1'b0;
      end else begin
         slope_ff <= slope_in;  bias_ff <= bias_in;
         cnt_ff <= cnt_in;  ovf_ff <= ovf_in;
         ri_ff <= ri_in;  rj_ff <= rj_in;  iss_end_ff <= iss_end_in;  pv_ff <= pv_in;
         k_ff <= k_in;  start_ff <= start_in;  bbeg_ff <= bbeg_in;  bend_ff <= bend_in;
         ph_ff <= ph_in;
         s_ff <= s_in;  sum_ff <= sum_in;  dcnt_ff <= dcnt_in;  dstart_ff <= dstart_in;
         e_ff <= e_in;  rv_ff <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      pi_ff <= pi_in;  pj_ff <= pj_in;  acc_ff <= acc_in;  plast_ff <= plast_in;
      prev_ff <= prev_in;  cur_ff <= cur_in;  prod_ff <= prod_in;
      quo_ff <= quo_in;  rem_ff <= rem_in;
      ridx_ff <= ridx_in;  rkeep_ff <= rkeep_in;  rovf_ff <= rovf_in;
      rlast_ff <= rlast_in;  rcnt_ff <= rcnt_in;  rest_ff <= rest_in;
   end

   assign rsp_valid    = rv_ff;
   assign rsp_index    = ridx_ff;
   assign rsp_keep     = rkeep_ff;
   assign rsp_count    = rcnt_ff;
   assign rsp_estimate = rest_ff;
   assign rsp_overflow = rovf_ff;
   assign rsp_last     = rlast_ff;

endmodule

/* design/offset_outlier_filter_mean.sv */
// ----------------------------------------------------------------------------
// offset_outlier_filter_mean
// Collects a set of offsets, keeps the longest consistent run and reports
// keep flags with the rounded mean of the kept offsets.
// ----------------------------------------------------------------------------
// Offsets load at one beat per cycle until the beat with tlast; items past
// MAX_ITEMS are dropped and flagged. With n offsets stored, the set is then
// ranked, scanned, summed and divided before the first result beat goes out.
// The ranking pass makes n*n pairwise compares, one per cycle, through the
// two read ports of the offset memory. No input is taken until the last
// result beat of a set has gone out.
module offset_outlier_filter_mean #(
   parameter int MAX_ITEMS   = oofm_pkg::DEF_MAX_ITEMS,
   parameter int OFFSET_BITS = oofm_pkg::DEF_OFFSET_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wen,
   input  logic [oofm_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [oofm_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((OFFSET_BITS+7)/8)*8-1:0]    req_tdata,  // offset_value
   input  logic                                req_tlast,  // last_item
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // item_index, keep, kept_count, offset_estimate, overflow
   output logic [oofm_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tlast   // last_result
);
   import oofm_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic [IDX_W-1:0]   rsp_index;
   logic               rsp_keep, rsp_overflow;
   logic [COUNT_W-1:0] rsp_count;
   logic [EST_W-1:0]   rsp_estimate;

   oofm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   oofm_dp #(
      .MAX_ITEMS   (MAX_ITEMS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_wen      (csr_wen),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .req_offset   (req_tdata[OFFSET_BITS-1:0]),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_ready    (rsp_tready),
      .rsp_valid    (rsp_tvalid),
      .rsp_index    (rsp_index),
      .rsp_keep     (rsp_keep),
      .rsp_count    (rsp_count),
      .rsp_estimate (rsp_estimate),
      .rsp_overflow (rsp_overflow),
      .rsp_last     (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, rsp_overflow, rsp_estimate, rsp_count, rsp_keep, rsp_index};

endmodule

/* tb/offset_outlier_filter_mean_tb.sv */
// ----------------------------------------------------------------------------
// offset_outlier_filter_mean_tb
// Streams sets of offsets into the outlier filter and checks every result
// beat (keep flag, kept count, rounded mean, overflow, tlast) against an
// in-bench model of the sort, run scan and mean. Tolerance registers are
// swept across defaults, extremes and random values between sets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module offset_outlier_filter_mean_tb;
   import oofm_pkg::*;

   typedef struct {
      logic [IDX_W-1:0]   idx;
      logic               keep;
      logic [COUNT_W-1:0] cnt;
      logic [EST_W-1:0]   est;
      logic               ovf;
      logic               lst;
   } filt_result_type;

   typedef struct {
      logic [23:0]        off;
      bit                 last;
      bit                 typed;   // single-offset set with known answer
      logic [EST_W-1:0]   est;
   } stim_row_type;

   logic                   clock = 0;
   logic                   reset = 1;
   logic                   csr_wen = 0;
   logic [CSR_ADDR_W-1:0]  csr_addr = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_tvalid = 0;
   logic                   req_tready;
   logic [23:0]            req_tdata = '0;  // offset_value
   logic                   req_tlast = 0;   // last_item
   logic                   rsp_tvalid;
   logic                   rsp_tready = 0;
   // item_index, keep, kept_count, offset_estimate, overflow
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;       // last_result

   offset_outlier_filter_mean u_top (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   logic [15:0]  slope_q16 = SLOPE_RESET;
   logic [15:0]  bias = BIAS_RESET;
   logic [23:0]  set_offs[$];
   bit           set_ovf = 0;
   filt_result_type expected_q[$];
   bit           no_idle = 0;
   int           errors = 0;
   int           n_beats = 0;
   int           n_sets = 0;
   int           n_ovf_sets = 0;

   function automatic bit is_break(logic [63:0] a, logic [63:0] b);
      logic [63:0] tol;
      if (a == b) return 0;
      tol = ((64'(slope_q16) * (a + b) + 64'd65536) >> 17) + 64'(bias);
      return (b - a) >= tol;
   endfunction

   // sort, longest run, mean; queues one result per stored offset
   task automatic predict_set();
      int          order[$];
      int          n, j, v, start, rb, re;
      logic [63:0] total, mean;
      bit          kept[64];
      filt_result_type r;
      n = set_offs.size();
      for (int i = 0; i < n; i++) order = {order, i};
      for (int i = 1; i < n; i++) begin
         v = order[i];
         j = i;
         while (j > 0 && set_offs[order[j-1]] > set_offs[v]) begin
            order[j] = order[j-1];
            j--;
         end
         order[j] = v;
      end
      start = 0; rb = 0; re = 0;
      for (int i = 1; i <= n; i++) begin
         if (i == n || is_break(64'(set_offs[order[i-1]]), 64'(set_offs[order[i]]))) begin
            if (i - start > re - rb) begin
               rb = start;
               re = i;
            end
            start = i;
         end
      end
      total = 0;
      foreach (kept[i]) kept[i] = 0;
      for (int i = rb; i < re; i++) begin
         total += 64'(set_offs[order[i]]);
         kept[order[i]] = 1;
      end
      mean = (re > rb) ? (total + 64'((re - rb) / 2)) / 64'(re - rb) : 64'd0;
      for (int i = 0; i < n; i++) begin
         r.idx = IDX_W'(i);
         r.keep = kept[i];
         r.cnt = COUNT_W'(re - rb);
         r.est = mean[23:0];
         r.ovf = set_ovf;
         r.lst = (i == n - 1);
         expected_q = {expected_q, r};
      end
      if (set_ovf) n_ovf_sets++;
      n_sets++;
      set_offs.delete();
      set_ovf = 0;
   endtask

   task automatic send_offset(logic [23:0] off, bit last, bit typed = 0,
                              logic [23:0] est = 0);
      filt_result_type r;
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= off;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      if (set_offs.size() < DEF_MAX_ITEMS) set_offs = {set_offs, off};
      else set_ovf = 1;
      if (last) begin
         if (typed) begin
            r = '{idx: 0, keep: 1, cnt: 1, est: est, ovf: 0, lst: 1};
            expected_q = {expected_q, r};
            n_sets++;
            set_offs.delete();
         end else begin
            predict_set();
         end
      end
   endtask

   task automatic write_csr(int idx, logic [15:0] val);
      req_tvalid <= 0;
      wait (expected_q.size() == 0);
      repeat (10) @(posedge clock);
      csr_wen   <= 1;
      csr_addr  <= CSR_ADDR_W'(idx);
      csr_wdata <= val;
      @(posedge clock);
      csr_wen   <= 0;
      if (idx == REG_SLOPE) slope_q16 = val;
      else bias = val;
   endtask

   task automatic send_random_set(int size);
      logic [23:0] base, spread;
      base   = 24'($urandom_range(0, 24'hFFFFFF));
      spread = 24'(1) << $urandom_range(0, 14);
      for (int i = 0; i < size; i++) begin
         if ($urandom_range(0, 9) == 0)
            send_offset(24'($urandom_range(0, 24'hFFFFFF)), i == size - 1);
         else if ($urandom_range(0, 7) == 0 && i > 0)
            send_offset(set_offs[$], i == size - 1);
         else
            send_offset(24'(base + $urandom_range(0, spread)), i == size - 1);
      end
   endtask

   stim_row_type directed[] = '{
      '{24'd0,       1, 1, 24'd0},
      '{24'hFFFFFF,  1, 1, 24'hFFFFFF},
      '{24'd1000,    0, 0, 0}, '{24'd1000, 0, 0, 0}, '{24'd1000, 1, 0, 0},
      '{24'd1000,    0, 0, 0}, '{24'd5000, 0, 0, 0}, '{24'd1010, 0, 0, 0},
      '{24'd1020,    1, 0, 0},
      '{24'd50000,   0, 0, 0}, '{24'd100,  0, 0, 0}, '{24'd50001, 0, 0, 0},
      '{24'd101,     1, 0, 0},
      '{24'hFFFFFF,  0, 0, 0}, '{24'd0,    1, 0, 0},
      '{24'd3,       0, 0, 0}, '{24'd1,    0, 0, 0}, '{24'd2,     1, 0, 0},
      '{24'hAAAAAA,  0, 0, 0}, '{24'h555555, 1, 0, 0}
   };

   initial begin
      int items, next_csr;
      repeat (8) @(posedge clock);
      reset <= 0;
      foreach (directed[i])
         send_offset(directed[i].off, directed[i].last, directed[i].typed,
                     directed[i].est);
      // overflow set: one past capacity and more
      send_random_set(DEF_MAX_ITEMS + 3);
      write_csr(REG_SLOPE, 16'd0);
      write_csr(REG_BIAS, 16'd0);
      send_random_set(6);
      send_random_set(DEF_MAX_ITEMS);
      write_csr(REG_SLOPE, 16'hFFFF);
      write_csr(REG_BIAS, 16'hFFFF);
      send_random_set(8);
      items = 0;
      next_csr = 50;
      while (items < 195) begin
         int sz;
         if (items >= next_csr) begin
            write_csr(REG_SLOPE, 16'($urandom_range(0, 16'hFFFF) >> $urandom_range(0, 10)));
            write_csr(REG_BIAS, 16'($urandom_range(0, 16'hFFFF) >> $urandom_range(0, 14)));
            next_csr += 50;
         end
         no_idle = (items > 150);
         case ($urandom_range(0, 19))
            0:       sz = $urandom_range(DEF_MAX_ITEMS - 2, DEF_MAX_ITEMS + 2);
            1:       sz = $urandom_range(16, 40);
            default: sz = $urandom_range(1, 10);
         endcase
         send_random_set(sz);
         items += sz;
      end
      req_tvalid <= 0;
      wait (expected_q.size() == 0);
      repeat (50) @(posedge clock);
      $display("covered %0d sets (%0d past capacity), %0d result beats checked",
               n_sets, n_ovf_sets, n_beats);
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!no_idle && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_tready <= 1;
      end
   end

   always @(posedge clock) begin
      filt_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_beats++;
         if (expected_q.size() == 0) begin
            $error("unexpected result beat %h", rsp_tdata);
            errors++;
         end else begin
            e = expected_q.pop_front();
            if (rsp_tdata[5:0] !== e.idx) begin
               $error("item_index exp %0d got %0d", e.idx, rsp_tdata[5:0]); errors++;
            end
            if (rsp_tdata[6] !== e.keep) begin
               $error("keep exp %0d got %0d", e.keep, rsp_tdata[6]); errors++;
            end
            if (rsp_tdata[13:7] !== e.cnt) begin
               $error("kept_count exp %0d got %0d", e.cnt, rsp_tdata[13:7]); errors++;
            end
            if (rsp_tdata[37:14] !== e.est) begin
               $error("offset_estimate exp %0d got %0d", e.est, rsp_tdata[37:14]);
               errors++;
            end
            if (rsp_tdata[38] !== e.ovf) begin
               $error("overflow exp %0d got %0d", e.ovf, rsp_tdata[38]); errors++;
            end
            if (rsp_tlast !== e.lst) begin
               $error("last_result exp %0d got %0d", e.lst, rsp_tlast); errors++;
            end
         end
      end
   end

   initial begin
      #3000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
